// ----- hw/rtl/scfla_pkg.sv -----
// Shared types, widths and codes for the size-class free-list allocator.
`default_nettype none

package scfla_pkg;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 18;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 32;
  localparam int WORD_W  = 20;   // arena word: link or size header
  localparam int HEAD_W  = 19;   // list head: valid bit + address

  // Parameter defaults
  localparam int DEF_WORD_BYTES   = 8;
  localparam int DEF_SMALL_LIMIT  = 256;
  localparam int DEF_BLOCK_BYTES  = 4096;
  localparam int DEF_ARENA_BLOCKS = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_ALLOC_HDR = 2'd2,
    OP_FREE_HDR  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_LARGE   = 2'd1,
    ST_OOM     = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SIZE,
    S_HEAD,
    S_LINK
  } seq_state_t;

  // Arena memory command: one read and one write port, byte addresses
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } arena_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scfla_req_if.sv -----
// Request channel: valid/ready plus one request word.
`default_nettype none

interface scfla_req_if import scfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, output opcode, output req_size, output block_addr,
                  input ready);
  modport sink   (input valid, input opcode, input req_size, input block_addr,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/scfla_rsp_if.sv -----
// Response channel: valid/ready plus one result word.
`default_nettype none

interface scfla_rsp_if import scfla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  result_addr;
  logic [STAT_W-1:0]  status;
  logic [TOTAL_W-1:0] large_bytes;

  modport source (output valid, output result_addr, output status, output large_bytes,
                  input ready);
  modport sink   (input valid, input result_addr, input status, input large_bytes,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/scfla_arena.sv -----
// Arena word memory: one write and one registered read per cycle, out-of-range reads as zero.
`default_nettype none

module scfla_arena import scfla_pkg::*; #(
  parameter int WORD_BYTES   = DEF_WORD_BYTES,
  parameter int BLOCK_BYTES  = DEF_BLOCK_BYTES,
  parameter int ARENA_BLOCKS = DEF_ARENA_BLOCKS
) (
  input  wire logic              clk,
  input  wire arena_cmd_t        cmd,
  output      logic [WORD_W-1:0] rd_data
);

  localparam int WSH        = $clog2(WORD_BYTES);
  localparam int SPAN       = 1 << ADDR_W;
  localparam int RAW_BYTES  = ARENA_BLOCKS * BLOCK_BYTES;
  localparam int USED_BYTES = (RAW_BYTES < SPAN) ? RAW_BYTES : SPAN;
  localparam int DEPTH      = USED_BYTES / WORD_BYTES;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int FULL_W     = ADDR_W - WSH;
  localparam int FW1        = FULL_W + 1;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] raw;
  logic              hit;
  logic [FULL_W-1:0] rd_word;
  logic [FULL_W-1:0] wr_word;
  logic              rd_in;
  logic              wr_in;

  assign rd_word = cmd.rd_addr[ADDR_W-1:WSH];
  assign wr_word = cmd.wr_addr[ADDR_W-1:WSH];
  assign rd_in   = FW1'(rd_word) < FW1'(DEPTH);
  assign wr_in   = FW1'(wr_word) < FW1'(DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in) begin
      mem[wr_word[IDX_W-1:0]] <= cmd.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      raw <= mem[rd_word[IDX_W-1:0]];
      hit <= rd_in;
    end
  end

  assign rd_data = hit ? raw : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/scfla_heads.sv -----
// Free-list head table: small memory with per-class valid flops cleared by reset.
`default_nettype none

module scfla_heads import scfla_pkg::*; #(
  parameter int NUM_CLASSES = DEF_SMALL_LIMIT / DEF_WORD_BYTES,
  localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [CLS_W-1:0]  rd_cls,
  input  wire logic              wr_en,
  input  wire logic [CLS_W-1:0]  wr_cls,
  input  wire logic [HEAD_W-1:0] wr_data,
  output      logic [HEAD_W-1:0] rd_data
);

  logic [HEAD_W-1:0]      mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] live;
  logic [HEAD_W-1:0]      raw;
  logic                   live_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (wr_en) begin
      live[wr_cls] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_cls] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      raw    <= mem[rd_cls];
      live_q <= live[rd_cls];
    end
  end

  // never-written class reads as an empty list
  assign rd_data = live_q ? raw : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/scfla_seq.sv -----
// Request sequencer: size rounding, list pop/push, bump allocation, result register.
`default_nettype none

module scfla_seq import scfla_pkg::*; #(
  parameter int WORD_BYTES   = DEF_WORD_BYTES,
  parameter int SMALL_LIMIT  = DEF_SMALL_LIMIT,
  parameter int BLOCK_BYTES  = DEF_BLOCK_BYTES,
  parameter int ARENA_BLOCKS = DEF_ARENA_BLOCKS,
  localparam int NUM_CLASSES = SMALL_LIMIT / WORD_BYTES,
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  scfla_req_if.sink              req,
  scfla_rsp_if.source            rsp,
  output      arena_cmd_t        arena_cmd,
  input  wire logic [WORD_W-1:0] arena_rd,
  output      logic              head_rd_en,
  output      logic [CLS_W-1:0]  head_rd_cls,
  output      logic              head_wr_en,
  output      logic [CLS_W-1:0]  head_wr_cls,
  output      logic [HEAD_W-1:0] head_wr_data,
  input  wire logic [HEAD_W-1:0] head_rd
);

  localparam int WSH    = $clog2(WORD_BYTES);
  localparam int CW1    = CLS_W + 1;
  localparam int REM_W  = $clog2(BLOCK_BYTES + 1);
  localparam int BU_W   = $clog2(ARENA_BLOCKS + 1);
  localparam int PROD_W = (BU_W + REM_W > ADDR_W) ? BU_W + REM_W : ADDR_W;
  localparam int RSZ_W  = SIZE_W + 1;

  // class = size / word, folded once into the class range
  function automatic logic [CLS_W-1:0] class_of(input logic [WORD_W-1:0] sz);
    logic [WORD_W-1:0] q;
    logic [CW1-1:0]    qn;
    logic [CW1-1:0]    qw;
    q  = sz >> WSH;
    qn = q[CW1-1:0];
    qw = (qn >= CW1'(NUM_CLASSES)) ? qn - CW1'(NUM_CLASSES) : qn;
    return qw[CLS_W-1:0];
  endfunction

  seq_state_t         state, state_next;
  op_t                op_q, op_next;
  logic [WORD_W-1:0]  sz_q, sz_next;
  logic [CLS_W-1:0]   cls_q, cls_next;
  logic [ADDR_W-1:0]  target_q, target_next;
  logic [ADDR_W-1:0]  ptr_q, ptr_next;
  logic [ADDR_W-1:0]  bump_ptr, bump_ptr_next;
  logic [REM_W-1:0]   bump_rem, bump_rem_next;
  logic [BU_W-1:0]    blocks_used, blocks_used_next;
  logic [TOTAL_W-1:0] large_total, large_total_next;

  logic               out_valid;
  logic [ADDR_W-1:0]  out_addr;
  status_t            out_status;
  logic [TOTAL_W-1:0] out_large;

  logic               accept;
  logic               go;
  logic               finish;
  logic [ADDR_W-1:0]  res_addr;
  status_t            res_status;
  logic [TOTAL_W-1:0] res_large;

  op_t                op_in;
  logic [RSZ_W-1:0]   ext_sz;
  logic [RSZ_W-1:0]   rnd_sz;
  logic [ADDR_W-1:0]  tgt_in;
  logic               is_alloc;
  logic               hdr_alloc;
  logic               sz_zero;
  logic               sz_large;
  logic               pop;
  logic               need_blk;
  logic               no_blk;
  logic [PROD_W-1:0]  blk_prod;
  logic [ADDR_W-1:0]  bump_p;
  logic [TOTAL_W:0]   lsum;
  logic [TOTAL_W-1:0] ladd;
  logic [TOTAL_W-1:0] lsub;
  logic [WORD_W-1:0]  rem_after;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign go        = !out_valid || rsp.ready;

  // input word decode
  assign op_in  = op_t'(req.opcode);
  assign ext_sz = RSZ_W'(req.req_size) + ((op_in == OP_ALLOC_HDR) ? RSZ_W'(WORD_BYTES) : '0);
  assign rnd_sz = (ext_sz + RSZ_W'(WORD_BYTES - 1)) & ~RSZ_W'(WORD_BYTES - 1);
  assign tgt_in = (op_in == OP_FREE_HDR) ? req.block_addr - ADDR_W'(WORD_BYTES)
                                          : req.block_addr;

  // held-request decode
  assign is_alloc  = (op_q == OP_ALLOC) || (op_q == OP_ALLOC_HDR);
  assign hdr_alloc = (op_q == OP_ALLOC_HDR);
  assign sz_zero   = (sz_q == '0);
  assign sz_large  = (sz_q >= WORD_W'(SMALL_LIMIT));
  assign pop       = is_alloc && !sz_zero && !sz_large && head_rd[HEAD_W-1];

  // bump path
  assign need_blk  = WORD_W'(bump_rem) < sz_q;
  assign no_blk    = blocks_used >= BU_W'(ARENA_BLOCKS);
  assign blk_prod  = PROD_W'(blocks_used) * PROD_W'(BLOCK_BYTES);
  assign bump_p    = need_blk ? blk_prod[ADDR_W-1:0] : bump_ptr;
  assign rem_after = (need_blk ? WORD_W'(BLOCK_BYTES) : WORD_W'(bump_rem)) - sz_q;

  // saturating large-byte total
  assign lsum = {1'b0, large_total} + (TOTAL_W + 1)'(sz_q);
  assign ladd = lsum[TOTAL_W] ? '1 : lsum[TOTAL_W-1:0];
  assign lsub = (large_total > TOTAL_W'(sz_q)) ? large_total - TOTAL_W'(sz_q) : '0;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (op_in == OP_FREE_HDR) ? S_SIZE : S_HEAD;
        end
      end
      S_SIZE: state_next = S_HEAD;
      S_HEAD: begin
        if (pop) begin
          state_next = S_LINK;
        end else if (go) begin
          state_next = S_IDLE;
        end
      end
      S_LINK: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op_next          = op_q;
    sz_next          = sz_q;
    cls_next         = cls_q;
    target_next      = target_q;
    ptr_next         = ptr_q;
    bump_ptr_next    = bump_ptr;
    bump_rem_next    = bump_rem;
    blocks_used_next = blocks_used;
    large_total_next = large_total;
    arena_cmd        = '0;
    head_rd_en       = 1'b0;
    head_rd_cls      = cls_q;
    head_wr_en       = 1'b0;
    head_wr_cls      = cls_q;
    head_wr_data     = {1'b1, target_q};
    finish           = 1'b0;
    res_addr         = '0;
    res_status       = ST_OK;
    res_large        = large_total;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next           = op_in;
          sz_next           = WORD_W'(rnd_sz);
          cls_next          = class_of(WORD_W'(rnd_sz));
          target_next       = tgt_in;
          arena_cmd.rd_en   = (op_in == OP_FREE_HDR);
          arena_cmd.rd_addr = tgt_in;
          head_rd_en        = (op_in != OP_FREE_HDR);
          head_rd_cls       = class_of(WORD_W'(rnd_sz));
        end
      end

      S_SIZE: begin
        // size header has arrived; fetch its class head
        sz_next     = arena_rd;
        cls_next    = class_of(arena_rd);
        head_rd_en  = 1'b1;
        head_rd_cls = class_of(arena_rd);
      end

      S_HEAD: begin
        if (sz_zero) begin
          res_status = ST_INVALID;
          finish     = go;
        end else if (sz_large) begin
          res_status = ST_LARGE;
          res_large  = is_alloc ? ladd : lsub;
          finish     = go;
          if (go) begin
            large_total_next = res_large;
          end
        end else if (pop) begin
          // fetch the link stored in the popped block
          ptr_next          = head_rd[ADDR_W-1:0];
          arena_cmd.rd_en   = 1'b1;
          arena_cmd.rd_addr = head_rd[ADDR_W-1:0];
        end else if (is_alloc) begin
          if (need_blk && no_blk) begin
            res_status = ST_OOM;
            finish     = go;
          end else begin
            res_addr = hdr_alloc ? bump_p + ADDR_W'(WORD_BYTES) : bump_p;
            finish   = go;
            if (go) begin
              bump_ptr_next     = bump_p + sz_q[ADDR_W-1:0];
              bump_rem_next     = rem_after[REM_W-1:0];
              blocks_used_next  = need_blk ? blocks_used + 1'b1 : blocks_used;
              arena_cmd.wr_en   = hdr_alloc;
              arena_cmd.wr_addr = bump_p;
              arena_cmd.wr_data = sz_q;
            end
          end
        end else begin
          // push: old head goes into the freed block
          finish = go;
          if (go) begin
            arena_cmd.wr_en   = 1'b1;
            arena_cmd.wr_addr = target_q;
            arena_cmd.wr_data = WORD_W'(head_rd);
            head_wr_en        = 1'b1;
            head_wr_data      = {1'b1, target_q};
          end
        end
      end

      S_LINK: begin
        res_addr = hdr_alloc ? ptr_q + ADDR_W'(WORD_BYTES) : ptr_q;
        finish   = go;
        if (go) begin
          head_wr_en        = 1'b1;
          head_wr_data      = arena_rd[HEAD_W-1:0];
          arena_cmd.wr_en   = hdr_alloc;
          arena_cmd.wr_addr = ptr_q;
          arena_cmd.wr_data = sz_q;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bump_ptr    <= '0;
      bump_rem    <= '0;
      blocks_used <= '0;
      large_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      bump_ptr    <= bump_ptr_next;
      bump_rem    <= bump_rem_next;
      blocks_used <= blocks_used_next;
      large_total <= large_total_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_next;
    sz_q     <= sz_next;
    cls_q    <= cls_next;
    target_q <= target_next;
    ptr_q    <= ptr_next;
    if (finish) begin
      out_addr   <= res_addr;
      out_status <= res_status;
      out_large  <= res_large;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_addr = out_addr;
  assign rsp.status      = out_status;
  assign rsp.large_bytes = out_large;

endmodule

`default_nettype wire

// ----- hw/rtl/size_class_free_list_allocator_unit.sv -----
// Top level of the size-class free-list allocator.
`default_nettype none

// Segregated free-list allocator. Each request word (alloc, free, alloc with
// size header, free via header) gives exactly one result word. Sizes are
// rounded up to whole words; a rounded size below SMALL_LIMIT picks a size
// class whose singly linked free list keeps its links inside the arena. An
// alloc pops its class list or, when the list is empty, bump-allocates from
// the current arena block, opening a new block when too little remains and
// reporting out-of-memory once all ARENA_BLOCKS are used. Large sizes are
// only counted in a saturating byte total; size zero reports invalid.
// Timing: one request is in flight at a time. Plain frees and allocs that
// bump go from accept through the head read back to idle, allocs that pop a
// list add a link read and header frees add a size-header read first (a
// header free never pops). The states follow the chain of synchronous reads:
// size header from the arena, then the class head, then the link word in the
// arena. The result sits in an output register, so a new request is taken
// while the previous result waits; a stalled result only holds back the
// completion of the next request. Head entries have reset-cleared valid
// bits, so no clearing pass is needed; arena words are undefined until
// written. WORD_BYTES must be a power of two.

module size_class_free_list_allocator_unit import scfla_pkg::*; #(
  parameter int WORD_BYTES   = DEF_WORD_BYTES,
  parameter int SMALL_LIMIT  = DEF_SMALL_LIMIT,
  parameter int BLOCK_BYTES  = DEF_BLOCK_BYTES,
  parameter int ARENA_BLOCKS = DEF_ARENA_BLOCKS
) (
  input wire logic    clk,
  input wire logic    rst,
  scfla_req_if.sink   req,
  scfla_rsp_if.source rsp
);

  localparam int NUM_CLASSES = SMALL_LIMIT / WORD_BYTES;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  arena_cmd_t        arena_cmd;
  logic [WORD_W-1:0] arena_rd;
  logic              head_rd_en;
  logic [CLS_W-1:0]  head_rd_cls;
  logic              head_wr_en;
  logic [CLS_W-1:0]  head_wr_cls;
  logic [HEAD_W-1:0] head_wr_data;
  logic [HEAD_W-1:0] head_rd;

  // control: decode, list pop/push, bump allocation, result register
  scfla_seq #(
    .WORD_BYTES   (WORD_BYTES),
    .SMALL_LIMIT  (SMALL_LIMIT),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .ARENA_BLOCKS (ARENA_BLOCKS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .arena_cmd    (arena_cmd),
    .arena_rd     (arena_rd),
    .head_rd_en   (head_rd_en),
    .head_rd_cls  (head_rd_cls),
    .head_wr_en   (head_wr_en),
    .head_wr_cls  (head_wr_cls),
    .head_wr_data (head_wr_data),
    .head_rd      (head_rd)
  );

  // class list heads
  scfla_heads #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_heads (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (head_rd_en),
    .rd_cls  (head_rd_cls),
    .wr_en   (head_wr_en),
    .wr_cls  (head_wr_cls),
    .wr_data (head_wr_data),
    .rd_data (head_rd)
  );

  // arena words: links and size headers
  scfla_arena #(
    .WORD_BYTES   (WORD_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .ARENA_BLOCKS (ARENA_BLOCKS)
  ) u_arena (
    .clk     (clk),
    .cmd     (arena_cmd),
    .rd_data (arena_rd)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/scfla_chk.sv -----
// Port-level checks for the allocator top level, attached by bind.
`default_nettype none

module scfla_chk import scfla_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [ADDR_W-1:0]  rsp_result_addr,
  input wire logic [STAT_W-1:0]  rsp_status,
  input wire logic [TOTAL_W-1:0] rsp_large_bytes
);

  // a pending result word holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_addr)
      && $stable(rsp_status) && $stable(rsp_large_bytes))
    else $error("result word changed while stalled");

  // one request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  // only a successful alloc returns an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> rsp_result_addr == '0)
    else $error("non-ok result carries an address");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind size_class_free_list_allocator_unit scfla_chk u_scfla_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_result_addr (rsp.result_addr),
  .rsp_status      (rsp.status),
  .rsp_large_bytes (rsp.large_bytes)
);

`default_nettype wire
